[hw/rtl/ppx_pkg.sv]
// Shared types and constants for the palette pixel expander strip.
package ppx_pkg;

  localparam int PALETTE_BYTES = 768;
  localparam int PAL_ENTRIES   = 256;
  localparam int CHANNELS      = 3;
  localparam int COLOR_BITS    = 6;
  localparam int ADDR_BITS     = 10;
  localparam int INDEX_BITS    = 8;
  localparam int CFG_DATA_BITS = 10;
  localparam int HEIGHT_LIMIT  = 512;
  localparam int HEIGHT_BITS   = 10;
  localparam int ROW_BITS      = 9;
  localparam int COUNT_BITS    = 4;
  localparam int OFFSET_BITS   = 23;
  localparam int PIX_POS_BITS  = OFFSET_BITS - 2;

  // floor(addr / 3) == (addr * 683) >> 11 for every addr below 768
  localparam int RECIP3_MUL    = 683;
  localparam int RECIP3_SHIFT  = 11;

  localparam logic [7:0] ALPHA_FULL = 8'hff;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COUNT  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] data;
  } pal_wr_t;

endpackage

[hw/rtl/ppx_if.sv]
// Stream interfaces for pixel/load beats in and expanded pixel beats out.
interface ppx_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [9:0] palette_address;
  logic [7:0] palette_value;
  logic [7:0] pixel_index;

  modport source (output valid, output cmd, output palette_address,
                  output palette_value, output pixel_index, input ready);
  modport sink   (input valid, input cmd, input palette_address,
                  input palette_value, input pixel_index, output ready);
endinterface

interface ppx_out_if;
  logic        valid;
  logic        ready;
  logic [22:0] byte_offset;
  logic [7:0]  blue_out;
  logic [7:0]  green_out;
  logic [7:0]  red_out;
  logic [7:0]  alpha_out;
  logic        last_pixel;

  modport source (output valid, output byte_offset, output blue_out, output green_out,
                  output red_out, output alpha_out, output last_pixel, input ready);
  modport sink   (input valid, input byte_offset, input blue_out, input green_out,
                  input red_out, input alpha_out, input last_pixel, output ready);
endinterface

[hw/rtl/ppx_palette.sv]
// Palette store: three 256-entry channel banks with registered reads.
module ppx_palette (
  input  logic                                        clk,
  input  ppx_pkg::pal_wr_t                            wr,
  input  logic                                        rd_en,
  input  logic [ppx_pkg::INDEX_BITS-1:0]              rd_index,
  output logic [ppx_pkg::CHANNELS-1:0][ppx_pkg::COLOR_BITS-1:0] rd_data
);
  import ppx_pkg::*;

  logic [2*ADDR_BITS-1:0] prod;
  logic [INDEX_BITS-1:0]  entry;
  logic [ADDR_BITS-1:0]   chan_full;
  logic [1:0]             chan;
  logic                   in_range;

  // Split byte address into entry and channel without a divider
  always_comb begin
    prod      = wr.addr * ADDR_BITS'(RECIP3_MUL);
    entry     = prod[RECIP3_SHIFT +: INDEX_BITS];
    chan_full = wr.addr - ADDR_BITS'({entry, 1'b0}) - ADDR_BITS'(entry);
    chan      = chan_full[1:0];
    in_range  = wr.addr < ADDR_BITS'(PALETTE_BYTES);
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_bank
    logic [COLOR_BITS-1:0] bank [PAL_ENTRIES];
    logic [COLOR_BITS-1:0] q;

    always_ff @(posedge clk) begin
      if (wr.en && in_range && chan == 2'(c)) begin
        bank[entry] <= wr.data;
      end
      if (rd_en) begin
        q <= bank[rd_index];
      end
    end

    assign rd_data[c] = q;
  end

endmodule

[hw/rtl/ppx_raster.sv]
// Column/row/image counters, register clamping and offset partial products.
module ppx_raster #(
  parameter int MAX_IMAGE_WIDTH = 512,
  parameter int MAX_IMAGE_COUNT = 8,
  parameter int WW  = $clog2(MAX_IMAGE_WIDTH + 1),
  parameter int CW  = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1,
  parameter int NNW = $clog2(MAX_IMAGE_COUNT + 1),
  parameter int NW  = (MAX_IMAGE_COUNT > 1) ? $clog2(MAX_IMAGE_COUNT) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [ppx_pkg::CFG_DATA_BITS-1:0]     cfg_width,
  input  logic [ppx_pkg::CFG_DATA_BITS-1:0]     cfg_height,
  input  logic [ppx_pkg::COUNT_BITS-1:0]        cfg_images,
  input  logic                                  step,
  output logic [WW-1:0]                         w,
  output logic [NW+WW-1:0]                      img_w,
  output logic [ppx_pkg::ROW_BITS+NNW-1:0]      row_n,
  output logic [CW-1:0]                         col,
  output logic                                  last
);
  import ppx_pkg::*;

  logic [HEIGHT_BITS-1:0] h;
  logic [NNW-1:0]         n;
  logic [ROW_BITS-1:0]    row;
  logic [NW-1:0]          img;
  logic [WW-1:0]          col_inc;
  logic [HEIGHT_BITS-1:0] row_inc;
  logic [NNW-1:0]         img_inc;
  logic                   col_wrap;
  logic                   row_wrap;
  logic                   img_wrap;

  // Zero reads as one, oversize reads as the limit
  always_comb begin
    if (cfg_width == '0) begin
      w = WW'(1);
    end else if (int'(cfg_width) > MAX_IMAGE_WIDTH) begin
      w = WW'(MAX_IMAGE_WIDTH);
    end else begin
      w = WW'(cfg_width);
    end

    if (cfg_height == '0) begin
      h = HEIGHT_BITS'(1);
    end else if (int'(cfg_height) > HEIGHT_LIMIT) begin
      h = HEIGHT_BITS'(HEIGHT_LIMIT);
    end else begin
      h = cfg_height;
    end

    if (cfg_images == '0) begin
      n = NNW'(1);
    end else if (int'(cfg_images) > MAX_IMAGE_COUNT) begin
      n = NNW'(MAX_IMAGE_COUNT);
    end else begin
      n = NNW'(cfg_images);
    end
  end

  always_comb begin
    col_inc  = WW'(col) + WW'(1);
    row_inc  = HEIGHT_BITS'(row) + HEIGHT_BITS'(1);
    img_inc  = NNW'(img) + NNW'(1);
    col_wrap = col_inc >= w;
    row_wrap = row_inc >= h;
    img_wrap = img_inc >= n;
    last     = col_wrap && row_wrap && img_wrap;
    img_w    = img * w;
    row_n    = row * n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      img <= '0;
    end else if (step) begin
      if (col_wrap) begin
        col <= '0;
        if (row_wrap) begin
          row <= '0;
          if (img_wrap) begin
            img <= '0;
          end else begin
            img <= NW'(img_inc);
          end
        end else begin
          row <= ROW_BITS'(row_inc);
        end
      end else begin
        col <= CW'(col_inc);
      end
    end
  end

endmodule

[hw/rtl/palette_pixel_expander_strip_unit.sv]
// Top level of the palette pixel expander strip.
//
// Indexed-color expander for a strip of equal images laid side by side.
// A load beat (cmd 0) writes one palette byte at palette_address
// (entry*3 + channel: red, green, blue); only its low six bits are kept
// and addresses of 768 and up are dropped. A pixel beat (cmd 1) looks up
// entry pixel_index and returns blue, green and red as the stored six bits
// shifted left by two, alpha 0xff, and the byte offset of the pixel in a
// 32-bit-per-pixel surface holding the configured number of images, each
// of the configured width and height. Pixels run in raster order within
// each image, one image after another; the final pixel of the strip
// raises last_pixel and the counters wrap. Load beats give no result.
// Register values of zero act as one and values above the limit act as
// the limit (MAX_IMAGE_WIDTH, 512, MAX_IMAGE_COUNT). Reading a palette
// entry that was never written returns undefined color.
// Throughput is one beat per clock while the output accepts. Stage 1
// reads the palette banks and registers the image and row partial
// products; stage 2 does the remaining multiply and add for the offset
// into the output register. While a finished beat waits at the output
// the middle stage still takes one more pixel (and any number of loads
// while it is empty); after that the input stalls until the output
// drains.
// Write configuration only while no pixel is in flight.
module palette_pixel_expander_strip_unit #(
  parameter int MAX_IMAGE_WIDTH = 512,
  parameter int MAX_IMAGE_COUNT = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  ppx_pkg::reg_idx_t                  cfg_index,
  input  logic [ppx_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  ppx_in_if.sink                             pix_in,
  ppx_out_if.source                          pix_out
);
  import ppx_pkg::*;

  localparam int WW  = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int CW  = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
  localparam int NNW = $clog2(MAX_IMAGE_COUNT + 1);
  localparam int NW  = (MAX_IMAGE_COUNT > 1) ? $clog2(MAX_IMAGE_COUNT) : 1;
  localparam int RNW = ROW_BITS + NNW;
  localparam int IWW = NW + WW;
  localparam int RWW = RNW + WW;

  // Configuration registers
  logic [CFG_DATA_BITS-1:0] cfg_width;
  logic [CFG_DATA_BITS-1:0] cfg_height;
  logic [COUNT_BITS-1:0]    cfg_images;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= CFG_DATA_BITS'(320);
      cfg_height <= CFG_DATA_BITS'(32);
      cfg_images <= COUNT_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg_width  <= cfg_data;
        REG_HEIGHT: cfg_height <= cfg_data;
        REG_COUNT:  cfg_images <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 frees up whenever it empties into stage 2
  logic s1_valid;
  logic s2_valid;
  logic s2_adv;
  logic s1_free;
  logic in_beat;
  logic pix_take;
  logic load_take;

  always_comb begin
    s2_adv    = s1_valid && (!s2_valid || pix_out.ready);
    s1_free   = !s1_valid || s2_adv;
    in_beat   = pix_in.valid && s1_free;
    pix_take  = in_beat && (pix_in.cmd == CMD_PIXEL);
    load_take = in_beat && (pix_in.cmd == CMD_LOAD);
  end

  assign pix_in.ready = s1_free;

  // Palette banks: write on load beats, read on pixel beats
  pal_wr_t                               pal_wr;
  logic [CHANNELS-1:0][COLOR_BITS-1:0]   pal_q;

  always_comb begin
    pal_wr.en   = load_take;
    pal_wr.addr = pix_in.palette_address;
    pal_wr.data = pix_in.palette_value[COLOR_BITS-1:0];
  end

  ppx_palette u_palette (
    .clk      (clk),
    .wr       (pal_wr),
    .rd_en    (pix_take),
    .rd_index (pix_in.pixel_index),
    .rd_data  (pal_q)
  );

  // Raster counters advance once per pixel beat
  logic [WW-1:0]  r_w;
  logic [IWW-1:0] r_img_w;
  logic [RNW-1:0] r_row_n;
  logic [CW-1:0]  r_col;
  logic           r_last;

  ppx_raster #(
    .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_COUNT (MAX_IMAGE_COUNT),
    .WW              (WW),
    .CW              (CW),
    .NNW             (NNW),
    .NW              (NW)
  ) u_raster (
    .clk        (clk),
    .rst        (rst),
    .cfg_width  (cfg_width),
    .cfg_height (cfg_height),
    .cfg_images (cfg_images),
    .step       (pix_take),
    .w          (r_w),
    .img_w      (r_img_w),
    .row_n      (r_row_n),
    .col        (r_col),
    .last       (r_last)
  );

  // Stage 1: partial products beside the registered palette read
  logic [WW-1:0]  s1_w;
  logic [IWW-1:0] s1_img_w;
  logic [RNW-1:0] s1_row_n;
  logic [CW-1:0]  s1_col;
  logic           s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_take) begin
      s1_valid <= 1'b1;
    end else if (s2_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      s1_w     <= r_w;
      s1_img_w <= r_img_w;
      s1_row_n <= r_row_n;
      s1_col   <= r_col;
      s1_last  <= r_last;
    end
  end

  // Stage 2: finish the offset; only the low bits survive the final mask
  logic [RWW-1:0]          row_line;
  logic [PIX_POS_BITS-1:0] pix_pos;

  always_comb begin
    row_line = s1_row_n * s1_w;
    pix_pos  = PIX_POS_BITS'(row_line) + PIX_POS_BITS'(s1_img_w)
             + PIX_POS_BITS'(s1_col);
  end

  logic [OFFSET_BITS-1:0] s2_offset;
  logic [COLOR_BITS-1:0]  s2_red;
  logic [COLOR_BITS-1:0]  s2_green;
  logic [COLOR_BITS-1:0]  s2_blue;
  logic                   s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= 1'b1;
    end else if (pix_out.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_offset <= {pix_pos, 2'b00};
      s2_red    <= pal_q[CH_RED];
      s2_green  <= pal_q[CH_GREEN];
      s2_blue   <= pal_q[CH_BLUE];
      s2_last   <= s1_last;
    end
  end

  // Drive the result beat
  assign pix_out.valid       = s2_valid;
  assign pix_out.byte_offset = s2_offset;
  assign pix_out.blue_out    = {s2_blue, 2'b00};
  assign pix_out.green_out   = {s2_green, 2'b00};
  assign pix_out.red_out     = {s2_red, 2'b00};
  assign pix_out.alpha_out   = ALPHA_FULL;
  assign pix_out.last_pixel  = s2_last;

endmodule

[verif/palette_pixel_expander_strip_unit_tb.sv]
// Self-checking testbench for the palette pixel expander strip: directed table, then random beats.
`timescale 1ns / 1ps

module palette_pixel_expander_strip_unit_tb;
  import ppx_pkg::*;

  localparam int MAX_W           = 512;
  localparam int MAX_N           = 8;
  localparam int PHASES          = 12;
  localparam int BEATS_PER_PHASE = 115;
  localparam int DRAIN_CYCLES    = 8;     // pipeline is two deep; leave margin
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DIRECTED_ROWS   = 19;

  // One expanded pixel as it leaves the block.
  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic [7:0]             blue, green, red, alpha;
    logic                   last;
  } expanded_px_t;

  // One row of the directed stimulus table. When typed is set, px is the
  // result read straight off the spec; otherwise the predictor supplies it.
  typedef struct {
    cmd_t         cmd;
    logic [9:0]   addr;
    logic [7:0]   value;
    logic [7:0]   index;
    bit           typed;
    expanded_px_t px;
  } beat_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  reg_idx_t cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  ppx_in_if  pix_in_ch ();
  ppx_out_if pix_out_ch ();

  palette_pixel_expander_strip_unit #(
    .MAX_IMAGE_WIDTH(MAX_W),
    .MAX_IMAGE_COUNT(MAX_N)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_in   (pix_in_ch),
    .pix_out  (pix_out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: palette, strip position counters and registers.
  // ---------------------------------------------------------------------
  logic [COLOR_BITS-1:0] pal_mem [PALETTE_BYTES];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned img_pos = 0;
  logic [9:0]  width_reg  = 10'd320;
  logic [9:0]  height_reg = 10'd32;
  logic [3:0]  count_reg  = 4'd1;

  // Pixels in flight, oldest first.
  expanded_px_t pending_pixels [$];

  // Stimulus bookkeeping: which channels of each entry have been loaded,
  // and the entries whose three channels are all known.
  bit [2:0] chan_seen [PAL_ENTRIES];
  int       usable_entries [$];

  bit src_steady = 1'b0;
  bit snk_steady = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;
  expanded_px_t want_px, got_px;

  // Zero acts as one, anything above the limit acts as the limit.
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Apply one accepted beat to the shadow; return 1 when it yields a pixel.
  function automatic bit expand_beat(input cmd_t cmd, input logic [9:0] addr,
                                     input logic [7:0] value, input logic [7:0] index,
                                     output expanded_px_t px);
    int unsigned w, h, n, base;
    px = '0;
    if (cmd == CMD_LOAD) begin
      // Drop writes past the end of the palette; keep six bits otherwise.
      if (addr < PALETTE_BYTES) pal_mem[addr] = value[COLOR_BITS-1:0];
      return 1'b0;
    end
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, HEIGHT_LIMIT);
    n = clamp_dim(count_reg, MAX_N);
    base = index * CHANNELS;
    px.offset = OFFSET_BITS'((img_pos * w + row_pos * n * w + col_pos) * 4);
    px.red    = {pal_mem[base + CH_RED], 2'b00};
    px.green  = {pal_mem[base + CH_GREEN], 2'b00};
    px.blue   = {pal_mem[base + CH_BLUE], 2'b00};
    px.alpha  = ALPHA_FULL;
    px.last   = (col_pos + 1 >= w) && (row_pos + 1 >= h) && (img_pos + 1 >= n);
    // Counters wrap as soon as they reach or pass the limit, so a shape
    // change mid-strip resynchronizes at the next wrap.
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        img_pos++;
        if (img_pos >= n) img_pos = 0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void note_palette_write(input logic [9:0] addr);
    int entry;
    entry = addr / CHANNELS;
    if (chan_seen[entry] != 3'b111) begin
      chan_seen[entry][addr % CHANNELS] = 1'b1;
      if (chan_seen[entry] == 3'b111) usable_entries.push_back(entry);
    end
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, name, want, want, got, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Input side: every beat waits a random gap, then holds until accepted.
  // Called and returns on a falling edge.
  // ---------------------------------------------------------------------
  task automatic send_beat(input cmd_t cmd, input logic [9:0] addr, input logic [7:0] value,
                           input logic [7:0] index, input bit typed,
                           input expanded_px_t typed_px);
    int gap;
    expanded_px_t px;
    gap = src_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      pix_in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in_ch.valid           <= 1'b1;
    pix_in_ch.cmd             <= cmd;
    pix_in_ch.palette_address <= addr;
    pix_in_ch.palette_value   <= value;
    pix_in_ch.pixel_index     <= index;
    @(posedge clk);
    while (!pix_in_ch.ready) @(posedge clk);
    // Beat accepted at this edge: advance the shadow and queue the pixel.
    if (expand_beat(cmd, addr, value, index, px))
      pending_pixels.push_back(typed ? typed_px : px);
    if (cmd == CMD_LOAD && addr < PALETTE_BYTES) note_palette_write(addr);
    @(negedge clk);
  endtask

  // Drop valid, wait out every pixel in flight, then let the pipe drain.
  task automatic settle();
    pix_in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all three registers back to back, then mirror them.
  task automatic write_shape(input logic [9:0] w, input logic [9:0] h, input logic [3:0] n);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_index <= REG_COUNT;
    cfg_data  <= CFG_DATA_BITS'(n);
    @(negedge clk);
    cfg_we     <= 1'b0;
    width_reg  = w;
    height_reg = h;
    count_reg  = n;
  endtask

  // Mostly well-formed traffic: whole-entry palette loads followed by pixels
  // drawn from loaded entries; a little noise from stray single loads,
  // some of them past the end of the palette (those are not counted).
  task automatic run_random(input int beats);
    int done, pick, entry, first_ch;
    logic [9:0] addr;
    done = 0;
    while (done < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 22 || usable_entries.size() == 0) begin
        entry    = $urandom_range(0, PAL_ENTRIES - 1);
        first_ch = $urandom_range(0, CHANNELS - 1);
        for (int k = 0; k < CHANNELS; k++)
          send_beat(CMD_LOAD, 10'(entry * CHANNELS + (first_ch + k) % CHANNELS),
                    8'($urandom), 8'($urandom), 1'b0, '0);
        done += CHANNELS;
      end else if (pick < 28) begin
        addr = 10'($urandom_range(0, 1023));
        send_beat(CMD_LOAD, addr, 8'($urandom), 8'($urandom), 1'b0, '0);
        if (addr < PALETTE_BYTES) done++;
      end else begin
        entry = usable_entries[$urandom_range(0, usable_entries.size() - 1)];
        send_beat(CMD_PIXEL, 10'($urandom), 8'($urandom), 8'(entry), 1'b0, '0);
        done++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed table, run at the reset shape (320 x 32, one image).
  // Entry 0 and entry 255 are loaded with extreme bytes; the upper two bits
  // of each byte must be dropped. Loads at 768 and 1023 fall past the
  // palette and must leave it alone. Entry 170 exercises alternating bits.
  // ---------------------------------------------------------------------
  beat_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{CMD_LOAD,  10'd0,    8'hff, 8'd0,   1'b0, '0},
    '{CMD_LOAD,  10'd1,    8'h00, 8'd0,   1'b0, '0},
    '{CMD_LOAD,  10'd2,    8'hc3, 8'd0,   1'b0, '0},
    '{CMD_PIXEL, 10'd0,    8'h00, 8'd0,   1'b1, '{23'd0,  8'h0c, 8'h00, 8'hfc, ALPHA_FULL, 1'b0}},
    '{CMD_LOAD,  10'd765,  8'h3f, 8'd255, 1'b0, '0},
    '{CMD_LOAD,  10'd766,  8'h80, 8'd255, 1'b0, '0},
    '{CMD_LOAD,  10'd767,  8'h55, 8'd255, 1'b0, '0},
    '{CMD_PIXEL, 10'd1023, 8'hff, 8'd255, 1'b1, '{23'd4,  8'h54, 8'h00, 8'hfc, ALPHA_FULL, 1'b0}},
    '{CMD_LOAD,  10'd1023, 8'hff, 8'd255, 1'b0, '0},
    '{CMD_LOAD,  10'd768,  8'h00, 8'd0,   1'b0, '0},
    '{CMD_PIXEL, 10'd0,    8'h00, 8'd255, 1'b1, '{23'd8,  8'h54, 8'h00, 8'hfc, ALPHA_FULL, 1'b0}},
    '{CMD_LOAD,  10'd1,    8'haa, 8'd0,   1'b0, '0},
    '{CMD_PIXEL, 10'd0,    8'h00, 8'd0,   1'b1, '{23'd12, 8'h0c, 8'ha8, 8'hfc, ALPHA_FULL, 1'b0}},
    '{CMD_LOAD,  10'd510,  8'h55, 8'd170, 1'b0, '0},
    '{CMD_LOAD,  10'd512,  8'h33, 8'd85,  1'b0, '0},
    '{CMD_LOAD,  10'd511,  8'haa, 8'd0,   1'b0, '0},
    '{CMD_PIXEL, 10'd341,  8'h5a, 8'd170, 1'b0, '0},
    '{CMD_PIXEL, 10'd682,  8'ha5, 8'd255, 1'b0, '0},
    '{CMD_PIXEL, 10'd0,    8'h00, 8'd0,   1'b0, '0}
  };

  // Shapes per phase: a plain small strip, the smallest, the largest, zero
  // (acts as one, so every pixel is the last), all-ones (clamps to the
  // limits), then a few more small ones. The last two are drawn at random.
  int unsigned shape_w [PHASES] = '{3, 1, 512, 0, 1023, 5, 2, 1, 4, 6, 0, 0};
  int unsigned shape_h [PHASES] = '{2, 1, 512, 0, 1023, 3, 5, 7, 4, 2, 0, 0};
  int unsigned shape_n [PHASES] = '{2, 1, 8,   0, 15,   8, 1, 2, 4, 3, 0, 0};

  initial begin
    rst                        = 1'b1;
    cfg_we                     = 1'b0;
    cfg_index                  = REG_WIDTH;
    cfg_data                   = '0;
    pix_in_ch.valid            = 1'b0;
    pix_in_ch.cmd              = CMD_LOAD;
    pix_in_ch.palette_address = '0;
    pix_in_ch.palette_value    = '0;
    pix_in_ch.pixel_index      = '0;
    pix_out_ch.ready           = 1'b0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r])
      send_beat(directed_rows[r].cmd, directed_rows[r].addr, directed_rows[r].value,
                directed_rows[r].index, directed_rows[r].typed, directed_rows[r].px);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p >= PHASES - 2) begin
        shape_w[p] = $urandom_range(1, 6);
        shape_h[p] = $urandom_range(1, 5);
        shape_n[p] = $urandom_range(1, 4);
      end
      // Some phases run back to back with no idling on one or both sides.
      src_steady = ($urandom_range(0, 3) == 0);
      snk_steady = ($urandom_range(0, 3) == 0);
      write_shape(10'(shape_w[p]), 10'(shape_h[p]), 4'(shape_n[p]));
      run_random(BEATS_PER_PHASE);
      settle();
    end

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Output side: stall a random number of cycles, then hold ready until a
  // beat goes through. With a zero stall ready simply stays high.
  initial begin : result_sink
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = snk_steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        pix_out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pix_out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!pix_out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare every accepted pixel beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pix_out_ch.valid && pix_out_ch.ready) begin
      got_px = '{pix_out_ch.byte_offset, pix_out_ch.blue_out, pix_out_ch.green_out,
                 pix_out_ch.red_out, pix_out_ch.alpha_out, pix_out_ch.last_pixel};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel beat: expected none, actual offset %0d",
                 $time, got_px.offset);
        mismatches++;
      end else begin
        want_px = pending_pixels.pop_front();
        compare_field("byte_offset", want_px.offset, got_px.offset);
        compare_field("blue_out",    want_px.blue,   got_px.blue);
        compare_field("green_out",   want_px.green,  got_px.green);
        compare_field("red_out",     want_px.red,    got_px.red);
        compare_field("alpha_out",   want_px.alpha,  got_px.alpha);
        compare_field("last_pixel",  want_px.last,   got_px.last);
      end
    end
  end

  // Hard stop if the run hangs on a handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

[filelist.f]
hw/rtl/ppx_pkg.sv
hw/rtl/ppx_if.sv
hw/rtl/ppx_palette.sv
hw/rtl/ppx_raster.sv
hw/rtl/palette_pixel_expander_strip_unit.sv
verif/palette_pixel_expander_strip_unit_tb.sv
